### rtl/core/assert_macros.svh
// Assertion macros shared by the skin-conductance decoder RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/skcd_pkg.sv
// Constants and types for the skin-conductance frame decoder.
// No dependencies.
package skcd_pkg;

    localparam int unsigned InBytes  = 1;
    localparam int unsigned CodeW    = 13;
    localparam int unsigned ResW     = 22;
    localparam int unsigned CondW    = 21;
    localparam int unsigned OutDataW = 56;   // 13 + 22 + 21, already whole bytes

    // Frame phases
    localparam logic [1:0] PhaseHigh = 2'd3;
    localparam logic [1:0] PhaseMid  = 2'd2;
    localparam logic [1:0] PhaseLow  = 2'd1;

    // Byte class limits
    localparam logic [7:0] ByteLimit = 8'd63;
    localparam logic [7:0] HighBase  = 8'd32;
    localparam logic [7:0] MidBase   = 8'd16;

    localparam logic [8:0]  ResPerCode = 9'd500;
    localparam logic [29:0] CondNum    = 30'd1000000000;

    // The quotient fits in 21 bits, so the top 9 dividend bits seed the remainder
    localparam logic [4:0]  DivLastBit = 5'(CondW - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

### rtl/core/skin_conductance_frame_decoder_core.sv
// Skin-conductance frame decoder: frame rebuild, scaling and bit-serial division.
// Depends on skcd_pkg and assert_macros.svh.
//
//  channel   | dir | beat content
//  ----------+-----+---------------------------------------------------------------
//  s_axis    | in  | tdata = rx_byte, tuser = operation (1 = stop), tlast = batch_end
//  m_axis    | out | tdata = raw_code, resistance, conductance
//
// A beat that does not complete a reported frame leaves the block idle and
// ready for the next beat. A frame-completing beat while output is enabled
// latches the code, then runs the 13x9 multiply, the restoring divider (one
// quotient bit a cycle) and the load of the output register.
// The output register holds a result while m_axis stalls; beats are taken
// meanwhile; the next divide result waits for it to empty and holds off beats.
// Synchronous active-low reset: phase to expect-high, output disabled, no beats.
`include "assert_macros.svh"

module skin_conductance_frame_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [8*skcd_pkg::InBytes-1:0] i_s_axis_tdata,  // [7:0] rx_byte
    input  logic                          i_s_axis_tlast,   // batch_end
    input  logic                          i_s_axis_tuser,   // [0] operation
    // Master stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [skcd_pkg::OutDataW-1:0] o_m_axis_tdata    // [12:0] raw_code,
                                                            // [34:13] resistance,
                                                            // [55:35] conductance
);
    import skcd_pkg::*;

    // Control state
    t_state              r_state, n_state;
    logic [1:0]          r_phase, n_phase;
    logic                r_en, n_en;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;

    // Datapath
    logic [CodeW-1:0]    r_partial, n_partial;
    logic [CodeW-1:0]    r_code, n_code;
    logic [ResW-1:0]     r_res, n_res;
    logic [ResW-1:0]     r_rem, n_rem;
    logic [CondW-1:0]    r_quot, n_quot;
    logic [OutDataW-1:0] r_out_data, n_out_data;

    logic                w_accept;
    logic [7:0]          w_byte;
    logic [CodeW-1:0]    w_sum;
    logic [ResW:0]       w_trial;
    logic [ResW:0]       w_diff;
    logic                w_out_free;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_byte     = i_s_axis_tdata[7:0];
    // Low byte closes the frame; its value is the low nibble
    assign w_sum      = r_partial + CodeW'(w_byte[3:0]);
    // One restoring step: shift in the next dividend bit, try to subtract
    assign w_trial    = {r_rem, CondNum[r_cnt]};
    assign w_diff     = w_trial - {1'b0, r_res};
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_en        = r_en;
        n_cnt       = r_cnt;
        n_partial   = r_partial;
        n_code      = r_code;
        n_res       = r_res;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;

        // Drop the held result once the sink takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser) begin
                        // Stop: resync phase, disable output, keep the partial code
                        n_phase = PhaseHigh;
                        n_en    = 1'b0;
                    end else begin
                        if (w_byte < ByteLimit) begin
                            if (w_byte >= HighBase && r_phase == PhaseHigh) begin
                                n_phase   = PhaseMid;
                                n_partial = {w_byte[4:0], 8'd0};
                            end else if (w_byte >= MidBase && w_byte < HighBase &&
                                         r_phase == PhaseMid) begin
                                n_phase   = PhaseLow;
                                n_partial = r_partial + {5'd0, w_byte[3:0], 4'd0};
                            end else if (w_byte < MidBase && r_phase == PhaseLow) begin
                                n_phase   = PhaseHigh;
                                n_partial = (w_sum == '0) ? CodeW'(1) : w_sum;
                                n_code    = n_partial;
                                // Report only if enabled before this beat
                                if (r_en) begin
                                    n_state = S_MUL;
                                end
                            end
                        end
                        // Batch end enables output after this beat
                        if (i_s_axis_tlast) begin
                            n_en = 1'b1;
                        end
                    end
                end
            end
            S_MUL: begin
                n_res   = ResW'(r_code * ResPerCode);
                n_rem   = ResW'(CondNum[29:CondW]);
                n_quot  = '0;
                n_cnt   = DivLastBit;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!w_diff[ResW]) begin
                    n_rem  = w_diff[ResW-1:0];
                    n_quot = {r_quot[CondW-2:0], 1'b1};
                end else begin
                    n_rem  = w_trial[ResW-1:0];
                    n_quot = {r_quot[CondW-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_DONE: begin
                // Hold until the output register is free, then load it
                if (w_out_free) begin
                    n_out_data  = {r_quot, r_res, r_code};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PhaseHigh;
            r_en        <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_partial   <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_en        <= n_en;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_partial   <= n_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_res      <= n_res;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Phase zero is unreachable from reset
    `ASSERT_ALWAYS(a_phase_nonzero, i_clk, i_rst_n, r_phase != 2'd0, "frame phase reached zero")
    // Restoring remainder stays below the divisor
    `ASSERT_IMPLIES(a_rem_below_res, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_res, "divider remainder not below divisor")
    // Bit counter never runs past the quotient width
    `ASSERT_IMPLIES(a_cnt_range, i_clk, i_rst_n, r_state == S_DIV, r_cnt <= DivLastBit, "divider bit counter out of range")
    // A reported code is never zero
    `ASSERT_IMPLIES(a_code_nonzero, i_clk, i_rst_n, r_out_valid, r_out_data[CodeW-1:0] != '0, "reported code is zero")

endmodule
